// ----- design/pltq_pkg.sv -----
`default_nettype none
package pltq_pkg;

    localparam int TXN_W = 8;
    localparam int TS_W  = 48;
    localparam int ST_W  = 3;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_WAIT    = 3'd1,
        ST_ABORT   = 3'd2,
        ST_FREED   = 3'd3,
        ST_HANDOFF = 3'd4,
        ST_REMOVED = 3'd5,
        ST_ERROR   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OWN,
        S_DECIDE,
        S_RD_ENT,
        S_CHK_ENT,
        S_SHIFT_UP,
        S_PLACE,
        S_RD_NEXT,
        S_SHIFT_DN,
        S_FINISH,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;      // capture input transaction
        logic rd_own;       // read owner entry
        logic rd_ent;       // read waiter at index
        logic ent_dec;      // index -= 1 (insert scan)
        logic ent_inc;      // index += 1 (scan / remove)
        logic wr_up;        // write read entry at index+1
        logic wr_new;       // write new entry at index
        logic wr_dn;        // write read entry at index-1
        logic set_idx_cnt;  // index = count
        logic set_idx_zero; // index = 0
        logic own_grant;    // owner = input
        logic own_free;
        logic own_from_ent; // owner = entry 0 (read data)
        logic cnt_inc;
        logic cnt_dec;
        logic set_status;
        status_t status;
    } pltq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_release;
        logic part_bad;
        logic own_valid;
        logic own_lt;      // owner stamp < ts
        logic own_match;   // owner txn == id
        logic cnt_zero;
        logic cnt_full;
        logic idx_zero;    // index == 0
        logic idx_last;    // index + 1 == count
        logic idx_end;     // index == count
        logic ent_ge;      // read entry stamp >= ts
        logic ent_match;   // read entry txn == id
    } pltq_sts_t;

endpackage
`default_nettype wire

// ----- design/pltq_if.sv -----
`default_nettype none
interface pltq_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/partition_lock_timestamp_queue.sv -----
`default_nettype none
// Timestamp-ordered lock table with a sorted wait list per partition.
// Input channel (req): cmd, partition, txn_id, txn_ts; a request locks,
// queues or aborts, a release frees, hands off or drops a waiter.
// Output channel (rsp): status, handoff_valid, handoff_txn, one per request.
// The block handles one transaction at a time: it takes an input in idle,
// reads the owner table, then walks the partition's wait list through the
// waiter memory: on insert each entry is read, compared and moved up, and
// on release each entry is read and, after the one dropped, moved down.
// The result is held in the output register until taken; a stalled receiver
// holds the block, and the next input is taken once the result has left.
// Reset frees all partitions and empties all wait lists at once; the owner
// and waiter memories are not cleared and are read only after being written.
module partition_lock_timestamp_queue #(
    parameter int PARTITIONS = 16,
    parameter int WAIT_DEPTH = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    pltq_if.sink     req,
    pltq_if.source   rsp
);
    import pltq_pkg::*;

    pltq_cmd_t  ctl;
    pltq_sts_t  sts;
    logic [2:0] status;
    logic [7:0] handoff_txn;

    pltq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    pltq_datapath #(.PARTITIONS(PARTITIONS), .WAIT_DEPTH(WAIT_DEPTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_cmd      (req.data[60]),
        .in_part     (req.data[59:56]),
        .in_id       (req.data[55:48]),
        .in_ts       (req.data[47:0]),
        .ctl         (ctl),
        .sts         (sts),
        .status      (status),
        .handoff_txn (handoff_txn)
    );

    // result packing: status, handoff_valid, handoff_txn
    assign rsp.data = {status, (status == ST_HANDOFF), handoff_txn};
endmodule
`default_nettype wire

// ----- design/pltq_ram.sv -----
`default_nettype none
module pltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/pltq_datapath.sv -----
`default_nettype none
module pltq_datapath #(
    parameter int PARTITIONS = 16,
    parameter int WAIT_DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_cmd,
    input  wire logic [3:0]            in_part,
    input  wire logic [7:0]            in_id,
    input  wire logic [47:0]           in_ts,
    input  wire pltq_pkg::pltq_cmd_t   ctl,
    output pltq_pkg::pltq_sts_t        sts,
    output logic [2:0]                 status,
    output logic [7:0]                 handoff_txn
);
    import pltq_pkg::*;

    localparam int PW  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int DW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW  = $clog2(WAIT_DEPTH + 1);
    localparam int IW  = CW + 1;
    localparam int OWN_W = TXN_W + TS_W;
    localparam int WDEPTH = PARTITIONS * WAIT_DEPTH;
    localparam int WAW = $clog2(WDEPTH + 1);

    logic            cmd_reg;
    logic [3:0]      part_in_reg;
    logic [PW-1:0]   part_reg;
    logic [7:0]      id_reg;
    logic [47:0]     ts_reg;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [PARTITIONS-1:0] own_valid_reg;
    logic [CW-1:0]   cnt_reg [PARTITIONS];
    logic [2:0]      status_reg;
    logic [7:0]      hoff_reg;

    logic [OWN_W-1:0] own_rdata, own_wdata, ent_rdata, ent_wdata;
    logic             own_we, ent_we;
    logic [IW-1:0]    ent_widx, ent_ridx;
    logic [WAW-1:0]   ent_waddr_w, ent_raddr_w;
    logic [CW-1:0]    cnt;

    assign cnt = cnt_reg[part_reg];

    // input capture
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg     <= in_cmd;
            part_in_reg <= in_part;
            part_reg    <= PW'(in_part);
            id_reg      <= in_id;
            ts_reg      <= in_ts;
        end
    end

    // scan index
    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.set_idx_cnt)
        begin
            idx_next = IW'(cnt);
        end
        else if (ctl.set_idx_zero)
        begin
            idx_next = '0;
        end
        else if (ctl.ent_dec)
        begin
            idx_next = idx_reg - 1'b1;
        end
        else if (ctl.ent_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            own_valid_reg <= '0;
            status_reg    <= '0;
            hoff_reg      <= '0;
            for (int i = 0; i < PARTITIONS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            idx_reg <= idx_next;
            if (ctl.own_grant || ctl.own_from_ent)
            begin
                own_valid_reg[part_reg] <= 1'b1;
            end
            if (ctl.own_free)
            begin
                own_valid_reg[part_reg] <= 1'b0;
            end
            if (ctl.cnt_inc)
            begin
                cnt_reg[part_reg] <= cnt + 1'b1;
            end
            if (ctl.cnt_dec)
            begin
                cnt_reg[part_reg] <= cnt - 1'b1;
            end
            // handoff keeps the new owner captured during the walk
            if (ctl.set_status)
            begin
                status_reg <= ctl.status;
                hoff_reg   <= (ctl.status == ST_HANDOFF) ? hoff_reg : 8'd0;
            end
            if (ctl.own_from_ent)
            begin
                hoff_reg <= ent_rdata[OWN_W-1 -: TXN_W];
            end
        end
    end

    // owner table
    assign own_we    = ctl.own_grant || ctl.own_from_ent;
    assign own_wdata = ctl.own_grant ? {id_reg, ts_reg} : ent_rdata;

    pltq_ram #(.WIDTH(OWN_W), .DEPTH(PARTITIONS)) u_own (
        .clk   (clk),
        .we    (own_we),
        .waddr (part_reg),
        .wdata (own_wdata),
        .raddr (part_reg),
        .rdata (own_rdata)
    );

    // wait list store, one row per partition
    always_comb
    begin
        ent_widx  = idx_reg;
        ent_wdata = ent_rdata;
        if (ctl.wr_up)
        begin
            ent_widx = idx_reg + 1'b1;
        end
        else if (ctl.wr_dn)
        begin
            ent_widx = idx_reg - 1'b1;
        end
        else if (ctl.wr_new)
        begin
            ent_wdata = {id_reg, ts_reg};
        end
    end

    assign ent_we   = ctl.wr_up || ctl.wr_dn || ctl.wr_new;
    // insert scan reads the entry just below the index
    assign ent_ridx = ctl.rd_ent ? idx_reg - 1'b1 : idx_reg;
    assign ent_waddr_w = WAW'(part_reg) * WAW'(WAIT_DEPTH) + WAW'(ent_widx[DW-1:0]);
    assign ent_raddr_w = WAW'(part_reg) * WAW'(WAIT_DEPTH) + WAW'(ent_ridx[DW-1:0]);

    pltq_ram #(.WIDTH(OWN_W), .DEPTH(WDEPTH)) u_wait (
        .clk   (clk),
        .we    (ent_we),
        .waddr ($clog2(WDEPTH)'(ent_waddr_w)),
        .wdata (ent_wdata),
        .raddr ($clog2(WDEPTH)'(ent_raddr_w)),
        .rdata (ent_rdata)
    );

    // status to controller
    always_comb
    begin
        sts.is_release = cmd_reg;
        sts.part_bad   = (32'(part_in_reg) >= PARTITIONS);
        sts.own_valid  = own_valid_reg[part_reg];
        sts.own_lt     = own_rdata[TS_W-1:0] < ts_reg;
        sts.own_match  = own_rdata[OWN_W-1 -: TXN_W] == id_reg;
        sts.cnt_zero   = (cnt == '0);
        sts.cnt_full   = (32'(cnt) >= WAIT_DEPTH);
        sts.idx_zero   = (idx_reg == '0);
        sts.idx_last   = (idx_reg + 1'b1 == IW'(cnt));
        sts.idx_end    = (idx_reg == IW'(cnt));
        sts.ent_ge     = !(ts_reg > ent_rdata[TS_W-1:0]);
        sts.ent_match  = ent_rdata[OWN_W-1 -: TXN_W] == id_reg;
    end

    assign status      = status_reg;
    assign handoff_txn = hoff_reg;
endmodule
`default_nettype wire

// ----- design/pltq_ctrl.sv -----
`default_nettype none
module pltq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire pltq_pkg::pltq_sts_t sts,
    output pltq_pkg::pltq_cmd_t      ctl
);
    import pltq_pkg::*;

    state_t state_reg, state_next;
    logic   rel_own_reg, rel_own_next;
    logic   hand_reg, hand_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rel_own_reg <= 1'b0;
            hand_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rel_own_reg <= rel_own_next;
            hand_reg    <= hand_next;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        rel_own_next = rel_own_reg;
        hand_next    = hand_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RD_OWN;
                end
            end
            S_RD_OWN:   state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (sts.part_bad)
                begin
                    state_next = S_OUT;
                end
                else if (!sts.is_release)
                begin
                    if (!sts.own_valid || !sts.own_lt || sts.cnt_full)
                    begin
                        state_next = S_OUT;
                    end
                    else if (sts.cnt_zero)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        state_next = S_RD_ENT;
                    end
                end
                else if (sts.own_valid && sts.own_match)
                begin
                    rel_own_next = 1'b1;
                    hand_next    = 1'b1;
                    state_next = sts.cnt_zero ? S_OUT : S_RD_NEXT;
                end
                else
                begin
                    rel_own_next = 1'b0;
                    hand_next    = 1'b0;
                    state_next = sts.cnt_zero ? S_OUT : S_RD_NEXT;
                end
            end
            // insert: idx points one above the candidate entry
            S_RD_ENT:   state_next = S_CHK_ENT;
            S_CHK_ENT:
            begin
                if (sts.ent_ge)
                begin
                    state_next = S_SHIFT_UP;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_SHIFT_UP: state_next = sts.idx_zero ? S_PLACE : S_RD_ENT;
            S_PLACE:    state_next = S_OUT;
            // release: idx walks the list, entry at idx is in read data
            S_RD_NEXT:  state_next = S_SHIFT_DN;
            S_SHIFT_DN:
            begin
                if (!rel_own_reg && sts.ent_match)
                begin
                    rel_own_next = 1'b1;
                end
                if (sts.idx_last)
                begin
                    state_next = (rel_own_reg || sts.ent_match) ? S_FINISH : S_OUT;
                end
                else
                begin
                    state_next = S_RD_NEXT;
                end
            end
            S_FINISH:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl       = '0;
        ctl.status = ST_ERROR;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.load_in = in_valid;
            end
            S_RD_OWN:   ctl.rd_own = 1'b1;
            S_DECIDE:
            begin
                ctl.set_idx_cnt = !sts.is_release;
                ctl.set_idx_zero = sts.is_release;
                if (sts.part_bad)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_ERROR;
                end
                else if (!sts.is_release)
                begin
                    if (!sts.own_valid)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_GRANTED;
                        ctl.own_grant  = 1'b1;
                    end
                    else if (!sts.own_lt)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_ABORT;
                    end
                    else if (sts.cnt_full)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_ERROR;
                    end
                end
                else if (sts.own_valid && sts.own_match && sts.cnt_zero)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_FREED;
                    ctl.own_free   = 1'b1;
                end
                else if (sts.cnt_zero)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_ERROR;
                end
            end
            // read the entry below idx and step idx down onto it
            S_RD_ENT:
            begin
                ctl.rd_ent  = 1'b1;
                ctl.ent_dec = 1'b1;
            end
            S_CHK_ENT:
            begin
                if (sts.ent_ge)
                begin
                    ctl.wr_up = 1'b1;
                end
                else
                begin
                    ctl.ent_inc = 1'b1;
                end
            end
            S_SHIFT_UP:  ;
            S_PLACE:
            begin
                ctl.wr_new     = 1'b1;
                ctl.cnt_inc    = 1'b1;
                ctl.set_status = 1'b1;
                ctl.status     = ST_WAIT;
            end
            S_RD_NEXT:   ;
            S_SHIFT_DN:
            begin
                // head moves to owner on handoff, later entries move down one
                if (rel_own_reg)
                begin
                    if (hand_reg && sts.idx_zero)
                    begin
                        ctl.own_from_ent = 1'b1;
                    end
                    else
                    begin
                        ctl.wr_dn = 1'b1;
                    end
                end
                if (!sts.idx_last)
                begin
                    ctl.ent_inc = 1'b1;
                end
                else if (!rel_own_reg && !sts.ent_match)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_ERROR;
                end
            end
            S_FINISH:
            begin
                ctl.cnt_dec    = 1'b1;
                ctl.set_status = 1'b1;
                ctl.status     = hand_reg ? ST_HANDOFF : ST_REMOVED;
            end
            S_OUT:       out_valid = 1'b1;
            default:     ;
        endcase
    end
endmodule
`default_nettype wire
